// ===== rtl/core/mpv_pkg.sv =====
// Shared types, codes and widths of the matrix product verifier.
package mpv_pkg;

  // Field widths of one item
  localparam int FUNC_W = 3;
  localparam int IDX_W = 10;
  localparam int ELEM_W = 32;
  localparam int ACC_W = 64;
  localparam int SIZE_W = 11;

  // Index width used to range-check row and col against any supported size
  localparam int IDX_EXT_W = 13;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic CFG_IDX_MATRIX_SIZE = 1'b0;

  localparam int MAX_DIM_DEFAULT = 1024;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_C = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WR_F = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BF_READ,
    ST_BF_MUL,
    ST_BF_ACC,
    ST_AP_READ,
    ST_AP_MUL_LO,
    ST_AP_MUL_HI,
    ST_CF_MUL,
    ST_CHK_ACC,
    ST_DONE
  } state_t;

  // Accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_SUB
  } acc_op_t;

  // Multiplier operand choices
  typedef enum logic [1:0] {
    MUL_B_F,
    MUL_A_PLO,
    MUL_A_PHI,
    MUL_C_F
  } mul_sel_t;

endpackage

// ===== rtl/core/mpv_if.sv =====
// Item channel interfaces: request items in, verdict items out.
interface mpv_req_if;
  import mpv_pkg::*;

  logic valid;
  logic ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, func, row, col, element_value, input ready);
  modport sink (input valid, func, row, col, element_value, output ready);
endinterface

interface mpv_rsp_if;
  logic valid;
  logic ready;
  logic products_match;

  modport source (output valid, products_match, input ready);
  modport sink (input valid, products_match, output ready);
endinterface

// ===== rtl/core/matrix_product_verifier.sv =====
// Freivalds check of A*B == C over stored matrices, one shared multiplier.
//
//   channel   dir   handshake       payload
//   request   in    valid/ready     func, row, col, element_value
//   verdict   out   valid/ready     products_match
//   apb       in    psel/penable    paddr, pwdata -> prdata (matrix_size)
//
// A check item with size n walks each term of B*f, then of A*(B*f) - C*f, its
// steps set by the one 33x33 multiplier and the single read port of each matrix
// memory; it ends early at the first row that differs. rst is synchronous; it
// clears the sequencer and sets matrix_size to 1, memories keep their contents.
// Loads are taken while a verdict waits on a stalled output; a new check waits
// to finish.
module matrix_product_verifier #(
  parameter int MAX_DIM = mpv_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  mpv_req_if.sink                         request,
  mpv_rsp_if.source                       verdict,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpv_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mpv_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mpv_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mpv_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
  localparam int MEM_DEPTH = 1 << (2 * IW);

  // Configuration register
  logic [SIZE_W-1:0] matrix_size;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_MATRIX_SIZE) ?
                  APB_DATA_W'(matrix_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_MATRIX_SIZE)) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  // Sequencer and datapath registers
  state_t state, state_next;
  logic [IW-1:0] i_cnt, k_cnt;
  logic [CW-1:0] n_run;
  logic [ACC_W-1:0] acc, acc_next, prod;
  logic match_flag;
  logic out_valid, out_match;

  // Memory read data
  logic [ELEM_W-1:0] rd_a, rd_b, rd_c, rd_f;
  logic [ACC_W-1:0] rd_p;

  // Control from the sequencer
  logic in_ready;
  acc_op_t acc_op;
  mul_sel_t mul_sel;
  logic rd_bf, rd_ap;

  // Decode accepted item
  logic in_acc;
  logic [IDX_EXT_W-1:0] row_x, col_x;
  logic row_ok, col_ok;
  logic [2*IW-1:0] wr_addr, rd_addr;
  logic we_a, we_b, we_c, we_f, start;
  logic [CW-1:0] n_eff;
  logic last_k, last_i;

  assign in_acc = request.valid && in_ready;
  assign row_x = IDX_EXT_W'(request.row);
  assign col_x = IDX_EXT_W'(request.col);
  assign row_ok = row_x < IDX_EXT_W'(MAX_DIM);
  assign col_ok = col_x < IDX_EXT_W'(MAX_DIM);
  assign wr_addr = {row_x[IW-1:0], col_x[IW-1:0]};
  assign rd_addr = {i_cnt, k_cnt};
  assign we_a = in_acc && (request.func == FUNC_WR_A) && row_ok && col_ok;
  assign we_b = in_acc && (request.func == FUNC_WR_B) && row_ok && col_ok;
  assign we_c = in_acc && (request.func == FUNC_WR_C) && row_ok && col_ok;
  assign we_f = in_acc && (request.func == FUNC_WR_F) && row_ok;
  assign start = in_acc && (request.func == FUNC_CHECK);

  // Clamp the configured size to the storage
  assign n_eff = (IDX_EXT_W'(matrix_size) > IDX_EXT_W'(MAX_DIM)) ?
                 CW'(MAX_DIM) : CW'(matrix_size);

  assign last_k = (CW'(k_cnt) + CW'(1)) == n_run;
  assign last_i = (CW'(i_cnt) + CW'(1)) == n_run;

  // Matrix and vector memories
  logic [ELEM_W-1:0] store_a [MEM_DEPTH];
  logic [ELEM_W-1:0] store_b [MEM_DEPTH];
  logic [ELEM_W-1:0] store_c [MEM_DEPTH];
  logic [ELEM_W-1:0] test_vector [2**IW];
  logic [ACC_W-1:0] partial_vector [2**IW];

  always_ff @(posedge clk) begin
    if (we_a) store_a[wr_addr] <= request.element_value;
    if (rd_ap) rd_a <= store_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) store_b[wr_addr] <= request.element_value;
    if (rd_bf) rd_b <= store_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_c) store_c[wr_addr] <= request.element_value;
    if (rd_ap) rd_c <= store_c[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_f) test_vector[row_x[IW-1:0]] <= request.element_value;
    if (rd_bf || rd_ap) rd_f <= test_vector[k_cnt];
  end

  always_ff @(posedge clk) begin
    if (state == ST_BF_ACC && last_k) partial_vector[i_cnt] <= acc_next;
    if (rd_ap) rd_p <= partial_vector[k_cnt];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = (n_eff == '0) ? ST_DONE : ST_BF_READ;
      end
      ST_BF_READ: state_next = ST_BF_MUL;
      ST_BF_MUL: state_next = ST_BF_ACC;
      ST_BF_ACC: begin
        state_next = (last_k && last_i) ? ST_AP_READ : ST_BF_READ;
      end
      ST_AP_READ: state_next = ST_AP_MUL_LO;
      ST_AP_MUL_LO: state_next = ST_AP_MUL_HI;
      ST_AP_MUL_HI: state_next = ST_CF_MUL;
      ST_CF_MUL: state_next = ST_CHK_ACC;
      ST_CHK_ACC: begin
        if (last_k && ((acc_next != '0) || last_i)) state_next = ST_DONE;
        else state_next = ST_AP_READ;
      end
      ST_DONE: begin
        if (!out_valid || verdict.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    acc_op = ACC_HOLD;
    mul_sel = MUL_B_F;
    rd_bf = 1'b0;
    rd_ap = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_BF_READ: rd_bf = 1'b1;
      ST_BF_MUL: mul_sel = MUL_B_F;
      ST_BF_ACC: acc_op = ACC_ADD;
      ST_AP_READ: rd_ap = 1'b1;
      ST_AP_MUL_LO: mul_sel = MUL_A_PLO;
      ST_AP_MUL_HI: begin
        mul_sel = MUL_A_PHI;
        acc_op = ACC_ADD;
      end
      ST_CF_MUL: begin
        mul_sel = MUL_C_F;
        acc_op = ACC_ADD_HI;
      end
      ST_CHK_ACC: acc_op = ACC_SUB;
      default: in_ready = 1'b0;
    endcase
  end

  assign request.ready = in_ready;

  // Shared multiplier operands
  logic signed [ELEM_W:0] mul_x, mul_y;
  logic signed [2*ELEM_W+1:0] mul_full;

  always_comb begin
    case (mul_sel)
      MUL_B_F: begin
        mul_x = {rd_b[ELEM_W-1], rd_b};
        mul_y = {rd_f[ELEM_W-1], rd_f};
      end
      MUL_A_PLO: begin
        mul_x = {rd_a[ELEM_W-1], rd_a};
        mul_y = {1'b0, rd_p[ELEM_W-1:0]};
      end
      MUL_A_PHI: begin
        mul_x = {rd_a[ELEM_W-1], rd_a};
        mul_y = {1'b0, rd_p[ACC_W-1:ELEM_W]};
      end
      MUL_C_F: begin
        mul_x = {rd_c[ELEM_W-1], rd_c};
        mul_y = {rd_f[ELEM_W-1], rd_f};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_full = mul_x * mul_y;

  // Accumulator, wrapping modulo 2^64
  always_comb begin
    case (acc_op)
      ACC_ADD: acc_next = acc + prod;
      ACC_ADD_HI: acc_next = acc + {prod[ELEM_W-1:0], {ELEM_W{1'b0}}};
      ACC_SUB: acc_next = acc - prod;
      default: acc_next = acc;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_full[ACC_W-1:0];
    case (state)
      ST_IDLE: begin
        acc <= '0;
        i_cnt <= '0;
        k_cnt <= '0;
        n_run <= n_eff;
        match_flag <= 1'b1;
      end
      ST_BF_ACC, ST_CHK_ACC: begin
        if (last_k) begin
          acc <= '0;
          k_cnt <= '0;
          i_cnt <= last_i ? '0 : i_cnt + IW'(1);
          if (state == ST_CHK_ACC && acc_next != '0) match_flag <= 1'b0;
        end else begin
          acc <= acc_next;
          k_cnt <= k_cnt + IW'(1);
        end
      end
      default: acc <= acc_next;
    endcase
  end

  // Control registers and verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!out_valid || verdict.ready)) begin
        out_valid <= 1'b1;
        out_match <= match_flag;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign verdict.valid = out_valid;
  assign verdict.products_match = out_match;

  // Checks
  a_check_blocks_input: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input taken while a check runs");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_DONE) |-> (CW'(k_cnt) < n_run && CW'(i_cnt) < n_run))
    else $error("walk index beyond matrix size");

  a_mismatch_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK_ACC && last_k && acc_next != '0) |=>
    (state == ST_DONE && !match_flag))
    else $error("row mismatch not reported");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && request.func != FUNC_CHECK) |=> !$rose(out_valid))
    else $error("load item produced a verdict");

endmodule
